FILE: hw/rtl/hvwn_pkg.sv
// package: item types, character codes and result bundle helper for the header value normalizer
package hvwn_pkg;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RES     = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_value;
        logic       end_of_field;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       field_done;
    } out_item_t;

    // all results caused by one input item, count is 0 to 3
    typedef struct packed {
        logic [1:0]                  count;
        out_item_t [MAX_RES-1:0]     res;
    } bundle_t;

    function automatic bundle_t add_res(bundle_t bdl, logic [7:0] b, logic v);
        bundle_t nb;
        nb = bdl;
        if (nb.count != 2'd3) begin
            nb.res[nb.count].out_byte   = b;
            nb.res[nb.count].out_valid  = v;
            nb.res[nb.count].field_done = 1'b0;
            nb.count                    = nb.count + 2'd1;
        end
        return nb;
    endfunction

endpackage

FILE: hw/rtl/hvwn_front.sv
// front end: accepts items, tracks value state and builds the result bundle per item
module hvwn_front import hvwn_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     cfg_valid,
    input  logic     cfg_data,
    input  logic     q_full,
    output logic     push,
    output bundle_t  push_bundle
);

    logic join_reg, join_next;
    logic held_cr_reg, held_cr_next;
    logic held_space_reg, held_space_next;
    logic after_white_reg, after_white_next;
    logic inside_value_reg, inside_value_next;
    logic value_seen_reg, value_seen_next;
    logic accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        bundle_t    bdl;
        logic       hcr, hsp, aw, iv, vs, eov, eof, drop;
        logic [7:0] b;

        bdl  = '0;
        hcr  = held_cr_reg;
        hsp  = held_space_reg;
        aw   = after_white_reg;
        iv   = inside_value_reg;
        vs   = value_seen_reg;
        b    = s_item.data_byte;
        eof  = s_item.end_of_field;
        eov  = s_item.end_of_value || eof;
        drop = 1'b0;

        if (!(vs && !join_reg)) begin
            if (!iv) begin
                iv  = 1'b1;
                hcr = 1'b0;
                hsp = 1'b0;
                aw  = 1'b1;
                if (vs) begin
                    bdl = add_res(bdl, CH_COMMA, 1'b1);
                end
            end
            if (s_item.has_byte) begin
                if (hcr) begin
                    hcr = 1'b0;
                    if (b == CH_LF) begin
                        drop = 1'b1;
                    end else begin
                        if (hsp) begin
                            bdl = add_res(bdl, CH_SP, 1'b1);
                            hsp = 1'b0;
                        end
                        bdl = add_res(bdl, CH_CR, 1'b1);
                        aw  = 1'b0;
                    end
                end
                if (!drop) begin
                    if (b == CH_CR) begin
                        hcr = 1'b1;
                    end else if (b != CH_SP && b != CH_TAB) begin
                        if (hsp) begin
                            bdl = add_res(bdl, CH_SP, 1'b1);
                            hsp = 1'b0;
                        end
                        bdl = add_res(bdl, b, 1'b1);
                        aw  = 1'b0;
                    end else if (!aw) begin
                        aw  = 1'b1;
                        hsp = 1'b1;
                    end
                end
            end
            if (eov) begin
                // a cr left at value end goes out as an ordinary byte
                if (hcr) begin
                    hcr = 1'b0;
                    if (hsp) begin
                        bdl = add_res(bdl, CH_SP, 1'b1);
                    end
                    bdl = add_res(bdl, CH_CR, 1'b1);
                end
                hsp = 1'b0;
                aw  = 1'b1;
                iv  = 1'b0;
                vs  = 1'b1;
            end
        end

        if (eof) begin
            if (bdl.count == 2'd0) begin
                bdl = add_res(bdl, 8'h00, 1'b0);
            end
            bdl.res[bdl.count - 2'd1].field_done = 1'b1;
            hcr = 1'b0;
            hsp = 1'b0;
            aw  = 1'b1;
            iv  = 1'b0;
            vs  = 1'b0;
        end

        push_bundle       = bdl;
        held_cr_next      = hcr;
        held_space_next   = hsp;
        after_white_next  = aw;
        inside_value_next = iv;
        value_seen_next   = vs;
    end

    // items that cause no result are not queued
    assign push      = accept && (push_bundle.count != 2'd0);
    assign join_next = cfg_valid ? cfg_data : join_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            join_reg         <= 1'b1;
            held_cr_reg      <= 1'b0;
            held_space_reg   <= 1'b0;
            after_white_reg  <= 1'b1;
            inside_value_reg <= 1'b0;
            value_seen_reg   <= 1'b0;
        end else begin
            join_reg <= join_next;
            if (accept) begin
                held_cr_reg      <= held_cr_next;
                held_space_reg   <= held_space_next;
                after_white_reg  <= after_white_next;
                inside_value_reg <= inside_value_next;
                value_seen_reg   <= value_seen_next;
            end
        end
    end

endmodule

FILE: hw/rtl/hvwn_queue.sv
// queue of result bundles between front and back
module hvwn_queue import hvwn_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_bundle,
    output logic    full,
    input  logic    pop,
    output bundle_t head,
    output logic    empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    bundle_t       mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/hvwn_back.sv
// back end: sends queued results one per cycle while m_ready allows, via an output register
module hvwn_back import hvwn_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  bundle_t   head,
    input  logic      empty,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic [1:0] idx_reg, idx_next;
    logic       m_valid_reg, m_valid_next;
    out_item_t  m_item_reg, m_item_next;
    logic       load, last;

    assign load = !empty && (!m_valid_reg || m_ready);
    assign last = (idx_reg == head.count - 2'd1);
    assign pop  = load && last;

    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (load) begin
            m_item_next  = head.res[idx_reg];
            m_valid_next = 1'b1;
            idx_next     = last ? 2'd0 : idx_reg + 2'd1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

FILE: hw/rtl/header_value_whitespace_normalizer.sv
// top level of the header value white-space normalizer
//
//  channel  direction  handshake              payload
//  s_       in         s_valid / s_ready      in_item_t   raw value bytes and end flags
//  m_       out        m_valid / m_ready      out_item_t  normalized bytes, end marker
//  cfg_     in         cfg_valid / cfg_ready  cfg_data    join_repeats
//
// one item accepted per cycle while the bundle queue has room; each item makes
// zero to three results, which leave one per cycle from the output register
// while m_ready is high
// the first result of an item passes through the bundle queue, then the output register
// reset (aresetn low, synchronous) empties the queue and sets join_repeats to 1
// a stalled output fills the queue, then s_ready drops; cfg_ready is always high
module header_value_whitespace_normalizer import hvwn_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic    q_full, q_empty, push, pop;
    bundle_t push_bundle, head;

    assign cfg_ready = 1'b1;

    hvwn_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .q_full      (q_full),
        .push        (push),
        .push_bundle (push_bundle)
    );

    hvwn_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (push),
        .push_bundle (push_bundle),
        .full        (q_full),
        .pop         (pop),
        .head        (head),
        .empty       (q_empty)
    );

    hvwn_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .empty   (q_empty),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

FILE: hw/rtl/hvwn_checker.sv
// port checker for the header value normalizer and its bind
module hvwn_checker import hvwn_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a waiting item holds until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("output item changed while stalled");

    // a bare marker always closes the field and carries a zero byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.out_valid |-> m_item.field_done && (m_item.out_byte == 8'h00))
        else $error("bare marker malformed");

    // tabs never reach the output; they are folded into a space or dropped
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.out_valid |-> m_item.out_byte != CH_TAB)
        else $error("tab on output");

    // nothing comes out right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind header_value_whitespace_normalizer hvwn_checker u_hvwn_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
